>>> hdl/rtq_pkg.sv
`default_nettype none
package rtq_pkg;
  localparam int NUM_SLOTS   = 16;
  localparam int TIME_BITS   = 32;
  localparam int REPEAT_BITS = 16;
  localparam int SLOT_BITS   = 4;
  localparam int STAMP_BITS  = 32;
  localparam int IDX_BITS    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_BITS    = $clog2(NUM_SLOTS + 1);
  localparam int MAX_OUT     = 16;

  typedef enum logic [2:0] {
    K_CREATE = 3'd0, K_PAUSE = 3'd1, K_RESUME = 3'd2, K_RESET = 3'd3,
    K_CANCEL = 3'd4, K_QUERY = 3'd5, K_TICK = 3'd6, K_CLEAR = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    M_FREE = 2'd0, M_ACTIVE = 2'd1, M_PAUSED = 2'd2, M_SPARE = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_CMD, S_SCAN, S_FIRE, S_OUT
  } fsm_t;

  // one slot's contents
  typedef struct packed {
    logic [1:0]             mode;
    logic [TIME_BITS-1:0]   dl;
    logic [TIME_BITS-1:0]   per;
    logic [REPEAT_BITS-1:0] rl;
    logic [REPEAT_BITS-1:0] ri;
    logic [STAMP_BITS-1:0]  stamp;
  } slot_t;

  // control to each cell
  typedef struct packed {
    logic                 clear;
    logic                 wr;
    logic [IDX_BITS-1:0]  wr_idx;
    slot_t                wr_data;
    logic                 shift;
  } cell_ctl_t;
endpackage
`default_nettype wire

>>> hdl/rtq_cell.sv
`default_nettype none
// One slot of the timer array; also carries one word of the rotating read ring.
module rtq_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [rtq_pkg::IDX_BITS-1:0] my_idx,
  input  wire rtq_pkg::cell_ctl_t       ctl,
  input  wire rtq_pkg::slot_t           ring_in,
  output rtq_pkg::slot_t                slot_q,
  output rtq_pkg::slot_t                ring_q
);
  import rtq_pkg::*;
  slot_t slot_r, ring_r;

  // slot storage: mode reset to free
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_r.mode <= M_FREE;
    end else if (ctl.clear) begin
      slot_r.mode <= M_FREE;
    end else if (ctl.wr && ctl.wr_idx == my_idx) begin
      slot_r <= ctl.wr_data;
    end
  end

  // ring: loads a copy while shift is low, passes it to the neighbor each cycle while shift is high
  always_ff @(posedge clk) begin
    if (ctl.shift) ring_r <= ring_in;
    else ring_r <= slot_r;
  end

  assign slot_q = slot_r;
  assign ring_q = ring_r;
endmodule
`default_nettype wire

>>> hdl/repeating_timer_queue.sv
`default_nettype none
// Channel | dir | tdata fields (low bit up)                   | tuser / tlast
// s_axis  | in  | slot[3:0] period[35:4] rc[51:36]             | tuser=kind
// m_axis  | out | slot_id[3:0] status[5:4] timer_state[7:6]    | tuser=event_res
//         |     | time_left[39:8] final_firing[40]             | tlast=last_of_run
// A command is accepted, decoded/updated, then its result is offered on m_axis.
// A tick is accepted and decoded, then makes one selection pass per due timer:
// a walk around the cell ring, then a fire step and a result step.
// A tick with nothing due ends after one pass with no result.
// One item is in work at a time; a stalled m_axis holds the block.
// rst (synchronous) frees all slots and clears clock and stamp counter.
module repeating_timer_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,   // slot, period, repeat_count
  input  wire logic [2:0]  s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // slot_id,status,timer_state,time_left,final_firing
  output logic             m_axis_tuser,   // event_res
  output logic             m_axis_tlast    // last_of_run
);
  import rtq_pkg::*;

  fsm_t state, state_next;
  logic [2:0]  kind;
  logic [3:0]  slot;
  logic [31:0] period;
  logic [15:0] rcnt;
  logic [TIME_BITS-1:0]  clk_t;
  logic [STAMP_BITS-1:0] stamp_cnt, base;
  logic [NUM_SLOTS-1:0]  due;
  logic [IDX_BITS-1:0]   scan_idx;
  logic [CNT_BITS-1:0]   scan_cnt;
  logic                  best_v;
  logic [IDX_BITS-1:0]   best_idx;
  logic [STAMP_BITS-1:0] best_age;

  cell_ctl_t ctl;
  slot_t slots [NUM_SLOTS];
  slot_t rings [NUM_SLOTS];

  // cell chain: ring rotates toward index 0
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    rtq_cell u_cell (
      .clk(clk), .rst(rst), .my_idx(IDX_BITS'(g)), .ctl(ctl),
      .ring_in(rings[(g + 1) % NUM_SLOTS]), .slot_q(slots[g]), .ring_q(rings[g])
    );
  end

  // result register
  logic       o_ev, o_fin, o_last;
  logic [3:0] o_slot;
  logic [1:0] o_st, o_md;
  logic [31:0] o_tl;
  assign m_axis_tdata  = {7'd0, o_fin, o_tl, o_md, o_st, o_slot};
  assign m_axis_tuser  = o_ev;
  assign m_axis_tlast  = o_last;
  assign m_axis_tvalid = (state == S_OUT);
  assign s_axis_tready = (state == S_IDLE);

  function automatic logic [31:0] left_of(slot_t s, logic [TIME_BITS-1:0] c);
    logic [TIME_BITS-1:0] d;
    d = s.dl - c;
    if (s.mode == M_ACTIVE) return 32'(d);
    if (s.mode == M_PAUSED) return 32'(s.dl);
    return 32'd0;
  endfunction

  // command decode on the addressed slot
  slot_t cs, cw;
  logic [1:0] cstat;
  logic cwr, cbump;
  logic [TIME_BITS-1:0]   sat_per;
  logic [REPEAT_BITS-1:0] sat_rc;
  logic slot_ok;
  always_comb begin
    slot_ok = ({28'd0, slot} < 32'(NUM_SLOTS));
    cs = slots[IDX_BITS'(slot)];
    cw = cs; cwr = 1'b0; cbump = 1'b0; cstat = ST_OK;
    if (TIME_BITS >= 32) sat_per = TIME_BITS'(period);
    else sat_per = (period > 32'((64'd1 << TIME_BITS) - 1)) ? '1 : TIME_BITS'(period);
    if (REPEAT_BITS >= 16) sat_rc = REPEAT_BITS'(rcnt);
    else sat_rc = (rcnt > 16'((32'd1 << REPEAT_BITS) - 1)) ? '1 : REPEAT_BITS'(rcnt);
    case (kind_t'(kind))
      K_CREATE: begin
        if (period == 32'd0) cstat = ST_ZERO;
        else begin
          cw.per = sat_per; cw.ri = sat_rc; cw.rl = sat_rc; cw.mode = M_ACTIVE;
          cw.dl = clk_t + sat_per; cw.stamp = stamp_cnt; cwr = 1'b1; cbump = 1'b1;
        end
      end
      K_PAUSE: begin
        if (cs.mode != M_ACTIVE) cstat = ST_BAD;
        else begin cw.dl = cs.dl - clk_t; cw.mode = M_PAUSED; cwr = 1'b1; end
      end
      K_RESUME: begin
        if (cs.mode != M_PAUSED) cstat = ST_BAD;
        else begin
          cw.dl = cs.dl + clk_t; cw.mode = M_ACTIVE; cw.stamp = stamp_cnt;
          cwr = 1'b1; cbump = 1'b1;
        end
      end
      K_RESET: begin
        if (cs.per == '0) cstat = ST_BAD;
        else begin
          cw.mode = M_ACTIVE; cw.dl = clk_t + cs.per; cw.rl = cs.ri;
          cw.stamp = stamp_cnt; cwr = 1'b1; cbump = 1'b1;
        end
      end
      K_CANCEL: begin
        if (cs.mode == M_FREE) cstat = ST_BAD;
        else begin cw.mode = M_FREE; cwr = 1'b1; end
      end
      default: ;
    endcase
    if (!slot_ok) begin cwr = 1'b0; cbump = 1'b0; cstat = ST_BAD; end
  end

  // firing update of the chosen slot
  slot_t fs, fw;
  logic ffin;
  logic [REPEAT_BITS-1:0] rl_dec;
  always_comb begin
    fs = slots[best_idx];
    fw = fs; ffin = 1'b0;
    rl_dec = fs.rl - 1'b1;
    if (fs.rl != '0) begin
      fw.rl = rl_dec;
      if (rl_dec == '0) begin fw.mode = M_FREE; ffin = 1'b1; end
    end
    if (!ffin) begin fw.dl = fs.dl + fs.per; fw.stamp = stamp_cnt; end
  end

  // ring head age for the selection pass
  logic [STAMP_BITS-1:0] head_age;
  logic head_better;
  assign head_age = base - rings[0].stamp;
  assign head_better = due[scan_idx] &&
                       (!best_v || head_age > best_age);

  // control sequencer
  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.shift = (state == S_SCAN);
    ctl.wr_data = cw;
    ctl.wr_idx = IDX_BITS'(slot);
    case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_CMD;
      S_CMD: begin
        if (kind_t'(kind) == K_CLEAR) begin
          ctl.clear = 1'b1; state_next = S_OUT;
        end else if (kind_t'(kind) == K_TICK) begin
          state_next = S_SCAN;
        end else begin
          ctl.wr = cwr; state_next = S_OUT;
        end
      end
      S_SCAN: if (scan_cnt == CNT_BITS'(NUM_SLOTS)) state_next = S_FIRE;
      S_FIRE: begin
        if (best_v) begin
          ctl.wr = 1'b1; ctl.wr_idx = best_idx; ctl.wr_data = fw;
          state_next = S_OUT;
        end else state_next = S_IDLE;
      end
      S_OUT: if (m_axis_tready) state_next = (o_ev && !o_last) ? S_SCAN : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // datapath registers
  logic [CNT_BITS-1:0] fired;
  always_ff @(posedge clk) begin
    if (rst) begin
      clk_t <= '0; stamp_cnt <= '0; due <= '0; fired <= '0;
    end else begin
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          kind <= s_axis_tuser; slot <= s_axis_tdata[3:0];
          period <= s_axis_tdata[35:4]; rcnt <= s_axis_tdata[51:36];
          scan_cnt <= '0; scan_idx <= '0; best_v <= 1'b0; fired <= '0;
        end
        S_CMD: begin
          o_ev <= 1'b0; o_fin <= 1'b0; o_last <= 1'b1;
          if (kind_t'(kind) == K_CLEAR) begin
            o_slot <= 4'd0; o_st <= ST_OK; o_md <= M_FREE; o_tl <= 32'd0;
          end else if (kind_t'(kind) == K_TICK) begin
            clk_t <= clk_t + 1'b1; base <= stamp_cnt;
            for (int i = 0; i < NUM_SLOTS; i++)
              due[i] <= (slots[i].mode == M_ACTIVE) && (slots[i].dl == clk_t + 1'b1);
          end else begin
            o_slot <= slot; o_st <= cstat;
            o_md <= slot_ok ? cw.mode : M_FREE;
            o_tl <= slot_ok ? left_of(cw, clk_t) : 32'd0;
            if (cbump) stamp_cnt <= stamp_cnt + 1'b1;
          end
        end
        S_SCAN: begin
          if (scan_cnt != CNT_BITS'(NUM_SLOTS)) begin
            if (head_better) begin
              best_v <= 1'b1; best_idx <= scan_idx; best_age <= head_age;
            end
            scan_idx <= (scan_idx == IDX_BITS'(NUM_SLOTS - 1)) ? '0 : scan_idx + 1'b1;
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_FIRE: if (best_v) begin
          due[best_idx] <= 1'b0;
          if (!ffin) stamp_cnt <= stamp_cnt + 1'b1;
          fired <= fired + 1'b1;
          o_ev <= 1'b1; o_slot <= 4'(best_idx); o_st <= ST_OK;
          o_md <= fw.mode; o_tl <= left_of(fw, clk_t); o_fin <= ffin;
          o_last <= ((due & ~(NUM_SLOTS'(1) << best_idx)) == '0) ||
                    (fired + 1'b1 == CNT_BITS'(MAX_OUT));
        end
        S_OUT: if (m_axis_tready) begin
          scan_cnt <= '0; scan_idx <= '0; best_v <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // beyond the report limit, remaining due timers are not fired; limit unreachable at 16 slots

  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  a_cmd_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast) else $error("reply not last");
endmodule
`default_nettype wire

>>> dv/repeating_timer_queue_test.sv
`default_nettype none
module repeating_timer_queue_test;
  import rtq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic        ev;
    logic [3:0]  slot;
    logic [1:0]  status;
    logic [1:0]  state;
    logic [31:0] left;
    logic        fin;
    logic        last;
  } timer_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  repeating_timer_queue dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // timer state mirror
  logic [1:0]  slot_mode [NUM_SLOTS];
  logic [31:0] slot_due [NUM_SLOTS];
  logic [31:0] slot_per [NUM_SLOTS];
  logic [15:0] reps_left [NUM_SLOTS];
  logic [15:0] reps_init [NUM_SLOTS];
  logic [31:0] slot_stamp [NUM_SLOTS];
  bit          slot_created [NUM_SLOTS];
  logic [31:0] tick_now;
  logic [31:0] stamp_next;

  timer_result_t pending_results[$];
  int  errors;
  int  cycles;
  bit  src_gaps;
  bit  sink_gaps;
  int  hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver readiness, with long hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= sink_gaps ? ($urandom_range(99) >= 31) : 1'b1;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    timer_result_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("[%0t] unexpected result from slot %0d", $realtime, m_axis_tdata[3:0]);
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (m_axis_tuser !== w.ev) report_mismatch("event_res", m_axis_tuser, w.ev);
        if (m_axis_tdata[3:0] !== w.slot) report_mismatch("slot_id", m_axis_tdata[3:0], w.slot);
        if (m_axis_tdata[5:4] !== w.status)
          report_mismatch("status", m_axis_tdata[5:4], w.status);
        if (m_axis_tdata[7:6] !== w.state)
          report_mismatch("timer_state", m_axis_tdata[7:6], w.state);
        if (m_axis_tdata[39:8] !== w.left)
          report_mismatch("time_left", m_axis_tdata[39:8], w.left);
        if (m_axis_tdata[40] !== w.fin)
          report_mismatch("final_firing", m_axis_tdata[40], w.fin);
        if (m_axis_tlast !== w.last) report_mismatch("last_of_run", m_axis_tlast, w.last);
      end
    end
  end

  function automatic logic [31:0] ticks_left(int s);
    if (slot_mode[s] == M_ACTIVE) return slot_due[s] - tick_now;
    if (slot_mode[s] == M_PAUSED) return slot_due[s];
    return 32'd0;
  endfunction

  function automatic void take_stamp(int s);
    slot_stamp[s] = stamp_next;
    stamp_next = stamp_next + 1;
  endfunction

  function automatic void rearm(int s);
    slot_mode[s] = M_ACTIVE;
    slot_due[s] = tick_now + slot_per[s];
    reps_left[s] = reps_init[s];
    take_stamp(s);
  endfunction

  function automatic void push_reply(logic [3:0] s, logic [1:0] st);
    timer_result_t e;
    e.ev = 1'b0;
    e.slot = s;
    e.status = st;
    e.state = slot_mode[s];
    e.left = ticks_left(int'(s));
    e.fin = 1'b0;
    e.last = 1'b1;
    pending_results.push_back(e);
  endfunction

  // advance the clock and queue the firings, oldest insertion first
  function automatic void fire_due_timers();
    int          due[$];
    logic [31:0] age[$];
    logic [31:0] base;
    logic [31:0] a;
    int          j;
    int          s;
    bit          fin;
    timer_result_t e;
    base = stamp_next;
    tick_now = tick_now + 1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_mode[i] == M_ACTIVE && slot_due[i] == tick_now) begin
        a = base - slot_stamp[i];
        j = due.size();
        while (j > 0 && age[j-1] < a) j--;
        due.insert(j, i);
        age.insert(j, a);
      end
    end
    for (int n = 0; n < due.size(); n++) begin
      s = due[n];
      fin = 1'b0;
      if (reps_left[s] > 0) begin
        reps_left[s] = reps_left[s] - 1;
        if (reps_left[s] == 0) begin
          slot_mode[s] = M_FREE;
          fin = 1'b1;
        end
      end
      if (!fin) begin
        slot_due[s] = slot_due[s] + slot_per[s];
        take_stamp(s);
      end
      if (n < MAX_OUT) begin
        e.ev = 1'b1;
        e.slot = s[3:0];
        e.status = ST_OK;
        e.state = slot_mode[s];
        e.left = ticks_left(s);
        e.fin = fin;
        e.last = (n == due.size() - 1) || (n == MAX_OUT - 1);
        pending_results.push_back(e);
      end
    end
  endfunction

  function automatic void predict_results(kind_t k, logic [3:0] s, logic [31:0] p,
                                          logic [15:0] r);
    logic [1:0] st;
    st = ST_OK;
    case (k)
      K_TICK: fire_due_timers();
      K_CLEAR: begin
        for (int i = 0; i < NUM_SLOTS; i++) slot_mode[i] = M_FREE;
        push_reply(4'd0, ST_OK);
      end
      default: begin
        case (k)
          K_CREATE: begin
            if (p == 0) begin
              st = ST_ZERO;
            end else begin
              slot_per[s] = p;
              reps_init[s] = r;
              slot_created[s] = 1'b1;
              rearm(s);
            end
          end
          K_PAUSE: begin
            if (slot_mode[s] != M_ACTIVE) begin
              st = ST_BAD;
            end else begin
              slot_due[s] = slot_due[s] - tick_now;
              slot_mode[s] = M_PAUSED;
            end
          end
          K_RESUME: begin
            if (slot_mode[s] != M_PAUSED) begin
              st = ST_BAD;
            end else begin
              slot_due[s] = slot_due[s] + tick_now;
              slot_mode[s] = M_ACTIVE;
              take_stamp(s);
            end
          end
          K_RESET: begin
            if (slot_per[s] == 0) st = ST_BAD;
            else rearm(s);
          end
          K_CANCEL: begin
            if (slot_mode[s] == M_FREE) st = ST_BAD;
            else slot_mode[s] = M_FREE;
          end
          default: ;
        endcase
        push_reply(s, st);
      end
    endcase
  endfunction

  // offer one request and wait for it to be taken
  task automatic send_request(kind_t k, logic [3:0] s, logic [31:0] p, logic [15:0] r);
    @(negedge clk);
    while (src_gaps && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= k;
    s_axis_tdata <= {4'b0, r, p, s};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_results(k, s, p, r);
  endtask

  task automatic test_directed();
    send_request(K_CREATE, 4'd3, 32'd0, 16'd5);
    send_request(K_CREATE, 4'd15, 32'd1, 16'd1);
    send_request(K_TICK, 4'd0, 32'd0, 16'd0);
    send_request(K_CREATE, 4'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(K_PAUSE, 4'd0, 32'd0, 16'd0);
    send_request(K_PAUSE, 4'd0, 32'd0, 16'd0);
    send_request(K_QUERY, 4'd0, 32'd0, 16'd0);
    send_request(K_RESUME, 4'd0, 32'd0, 16'd0);
    send_request(K_RESUME, 4'd0, 32'd0, 16'd0);
    send_request(K_RESET, 4'd0, 32'd0, 16'd0);
    send_request(K_CANCEL, 4'd0, 32'd0, 16'd0);
    send_request(K_CANCEL, 4'd0, 32'd0, 16'd0);
    send_request(K_RESET, 4'd15, 32'd0, 16'd0);
    // equal deadlines: firing order follows insertion age
    send_request(K_CREATE, 4'd9, 32'd2, 16'd0);
    send_request(K_CREATE, 4'd1, 32'd2, 16'd2);
    send_request(K_CREATE, 4'd5, 32'd1, 16'd3);
    send_request(K_CREATE, 4'd5, 32'd2, 16'd1);
    send_request(K_TICK, 4'd7, 32'd0, 16'd0);
    send_request(K_TICK, 4'd0, 32'd0, 16'd0);
    send_request(K_QUERY, 4'd9, 32'd0, 16'd0);
    send_request(K_CLEAR, 4'd12, 32'hDEAD_BEEF, 16'h1234);
    send_request(K_QUERY, 4'd9, 32'd0, 16'd0);
  endtask

  // every slot due on the same tick while the receiver holds off
  task automatic test_full_burst();
    src_gaps = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++)
      send_request(K_CREATE, i[3:0], 32'd2, 16'd2);
    hold_cycles = 600;
    for (int i = 0; i < 6; i++) send_request(K_TICK, 4'd0, 32'd0, 16'd0);
    for (int i = 0; i < 4; i++) send_request(K_QUERY, i[3:0], 32'd0, 16'd0);
    src_gaps = 1'b1;
  endtask

  task automatic test_random(int count);
    int          pick;
    logic [3:0]  s;
    logic [31:0] p;
    logic [15:0] r;
    kind_t       k;
    for (int n = 0; n < count; n++) begin
      // no gaps on either side for a stretch in the middle
      src_gaps = !(n >= count / 3 && n < count / 2);
      sink_gaps = src_gaps;
      pick = $urandom_range(99);
      s = $urandom_range(15);
      p = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(6));
      r = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
      if (pick < 38) k = K_TICK;
      else if (pick < 60) k = K_CREATE;
      else if (pick < 68) k = K_PAUSE;
      else if (pick < 76) k = K_RESUME;
      else if (pick < 83) k = K_RESET;
      else if (pick < 90) k = K_CANCEL;
      else if (pick < 98) k = K_QUERY;
      else k = K_CLEAR;
      // a slot never created must not be reset
      if (k == K_RESET && !slot_created[s]) k = K_QUERY;
      send_request(k, s, p, r);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    errors = 0;
    hold_cycles = 0;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    tick_now = '0;
    stamp_next = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_mode[i] = M_FREE;
      slot_due[i] = '0;
      slot_per[i] = '0;
      reps_left[i] = '0;
      reps_init[i] = '0;
      slot_stamp[i] = '0;
      slot_created[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_burst();
    test_random(330);

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
